// File: src/mtts_pkg.sv
package mtts_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SPEED_W     = 24;
    localparam int ELAPSED_W   = 16;
    localparam int CMD_W       = 3;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ROT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MOV_POS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOV_ROT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the item's command and fields
        logic chan_rot;  // channel being advanced: 0 position, 1 rotation
        logic diff;      // form axis differences and square sum
        logic sqrt_go;   // start the root
        logic div_go;    // start the fraction divide
        logic mul_go;    // start the per-axis scaling
        logic apply;     // write the channel's new values
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_tick;
        logic pos_active;
        logic rot_active;
        logic sqrt_done;
        logic div_done;
        logic mul_done;
        logic snap;      // step reaches the remaining distance
    } t_dp_sts;

endpackage

// File: src/mtts_ctrl.sv
module mtts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_fire,
    input  mtts_pkg::t_dp_sts i_sts,
    output mtts_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_PICK, S_DIFF, S_SQRT, S_CHECK, S_DIV, S_MUL, S_APPLY, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:  if (i_in_fire) r_state <= S_LOAD;
                S_LOAD: begin
                    r_chan  <= 1'b0;
                    r_state <= i_sts.is_tick ? S_PICK : S_OUT;
                end
                S_PICK: begin
                    if (!r_chan && i_sts.pos_active) r_state <= S_DIFF;
                    else if (r_chan && i_sts.rot_active) r_state <= S_DIFF;
                    else r_state <= S_NEXT;
                end
                S_DIFF:  r_state <= S_SQRT;
                S_SQRT:  if (i_sts.sqrt_done) r_state <= S_CHECK;
                S_CHECK: r_state <= i_sts.snap ? S_APPLY : S_DIV;
                S_DIV:   if (i_sts.div_done) r_state <= S_MUL;
                S_MUL:   if (i_sts.mul_done) r_state <= S_APPLY;
                S_APPLY: r_state <= S_NEXT;
                S_NEXT: begin
                    if (r_chan) r_state <= S_OUT;
                    else begin
                        r_chan  <= 1'b1;
                        r_state <= S_PICK;
                    end
                end
                S_OUT:   if (i_out_fire) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.chan_rot = r_chan;
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.diff     = (r_state == S_DIFF);
        o_cmd.sqrt_go  = (r_state == S_DIFF);
        o_cmd.div_go   = (r_state == S_CHECK) && !i_sts.snap;
        o_cmd.mul_go   = (r_state == S_DIV) && i_sts.div_done;
        o_cmd.apply    = (r_state == S_APPLY);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

    a_out_only_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result shown while idle");
    a_load_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire && !o_busy |=> o_cmd.load) else $error("accepted item not loaded");
    a_apply_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> !o_cmd.apply) else $error("channel applied twice");

endmodule

// File: src/mtts_dp.sv
module mtts_dp #(
    parameter int CoordWidth = mtts_pkg::COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mtts_pkg::SPEED_W-1:0]      i_cfg_data,
    input  logic [mtts_pkg::CMD_W-1:0]        i_command,
    input  logic signed [31:0]                i_cx,
    input  logic signed [31:0]                i_cy,
    input  logic signed [31:0]                i_cz,
    input  logic [mtts_pkg::ELAPSED_W-1:0]    i_elapsed,
    input  logic                              i_in_fire,
    input  mtts_pkg::t_dp_cmd                 i_cmd,
    output mtts_pkg::t_dp_sts                 o_sts,
    output logic [6*32+1:0]                   o_result
);

    localparam int CW  = CoordWidth;
    localparam int DW  = CW + 1;              // axis difference
    localparam int SW  = 2 * DW + 2;          // square sum
    localparam int RW  = (SW + 1) / 2;        // root width
    localparam int RCW = $clog2(RW + 1);
    localparam int FW  = 32;                  // fraction bits
    localparam int QW  = CW + FW;             // step << 32
    localparam int QCW = $clog2(QW + 1);
    localparam int PW  = 40;                  // step product width
    localparam int MCW = $clog2(FW + 1);
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] r_pos [3];
    logic signed [CW-1:0] r_rot [3];
    logic signed [CW-1:0] r_pt  [3];
    logic signed [CW-1:0] r_rt  [3];
    logic r_pa, r_ra;
    logic [mtts_pkg::SPEED_W-1:0]   r_speed;
    logic [mtts_pkg::CMD_W-1:0]     r_cmd;
    logic signed [CW-1:0]           r_c [3];
    logic [mtts_pkg::ELAPSED_W-1:0] r_el;
    logic [CW-2:0]                  r_step;

    // Input coordinates, sign-extended or saturated to CW.
    function automatic logic signed [CW-1:0] fit(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'(CMAX)) fit = CMAX;
        else if (w < 64'(CMIN)) fit = CMIN;
        else fit = CW'(w);
    endfunction

    // Channel operands.
    logic signed [CW-1:0] w_cur [3];
    logic signed [CW-1:0] w_tgt [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cur[i] = i_cmd.chan_rot ? r_rot[i] : r_pos[i];
            w_tgt[i] = i_cmd.chan_rot ? r_rt[i]  : r_pt[i];
        end
    end

    logic signed [DW-1:0] r_d [3];
    logic [DW-1:0] r_m [3];
    logic [SW-1:0] r_sum;
    logic signed [DW-1:0] w_d [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]  = DW'(w_tgt[i]) - DW'(w_cur[i]);
        end
    end

    // Square sum formed one axis a cycle.
    logic [1:0] r_sq_i;
    logic       r_sq_run;

    // Bitwise square root.
    logic [SW-1:0]  r_rad;
    logic [RW-1:0]  r_root;
    logic [SW+1:0]  r_rrem;
    logic [RCW-1:0] r_rcnt;
    logic           r_srun, r_sdone;

    // Restoring divide of step<<32 by root.
    logic [QW-1:0]  r_num;
    logic [RW:0]    r_drem;
    logic [FW-1:0]  r_frac;
    logic [QCW-1:0] r_dcnt;
    logic           r_drun, r_ddone;

    // Per-axis scaling, shift-add for all three axes.
    logic [DW+FW-1:0] r_acc [3];
    logic [MCW-1:0]   r_mcnt;
    logic             r_mrun, r_mdone;

    logic [PW-1:0] w_prod;
    assign w_prod = PW'(r_el) * PW'(r_speed);
    logic [PW-13:0] w_stepr;
    assign w_stepr = w_prod[PW-1:12];

    // The root is always at least as wide as the step.
    logic w_snap;
    assign w_snap = (r_root <= RW'(r_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0; r_rot[i] <= '0; r_pt[i] <= '0; r_rt[i] <= '0;
            end
            r_pa <= 1'b0; r_ra <= 1'b0; r_speed <= '0;
            r_sq_run <= 1'b0; r_srun <= 1'b0; r_sdone <= 1'b0;
            r_drun <= 1'b0; r_ddone <= 1'b0; r_mrun <= 1'b0; r_mdone <= 1'b0;
        end else begin
            if (i_cfg_we) r_speed <= i_cfg_data;
            if (i_in_fire) begin
                r_cmd  <= i_command;
                r_c[0] <= fit(i_cx); r_c[1] <= fit(i_cy); r_c[2] <= fit(i_cz);
                r_el   <= i_elapsed;
            end
            if (i_cmd.load) begin
                if (w_stepr > (PW-12)'(CMAX)) r_step <= (CW-1)'(CMAX);
                else r_step <= (CW-1)'(w_stepr);
                case (r_cmd)
                    mtts_pkg::CMD_SET_POS: for (int i = 0; i < 3; i++) r_pos[i] <= r_c[i];
                    mtts_pkg::CMD_SET_ROT: for (int i = 0; i < 3; i++) r_rot[i] <= r_c[i];
                    mtts_pkg::CMD_MOV_POS: begin
                        for (int i = 0; i < 3; i++) r_pt[i] <= r_c[i];
                        r_pa <= 1'b1;
                    end
                    mtts_pkg::CMD_MOV_ROT: begin
                        for (int i = 0; i < 3; i++) r_rt[i] <= r_c[i];
                        r_ra <= 1'b1;
                    end
                    mtts_pkg::CMD_STOP: begin
                        r_pa <= 1'b0; r_ra <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.diff) begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= w_d[i];
                    r_m[i] <= w_d[i][DW-1] ? DW'(-w_d[i]) : DW'(w_d[i]);
                end
                r_sum    <= '0;
                r_sq_i   <= '0;
                r_sq_run <= 1'b1;
                r_sdone  <= 1'b0;
            end
            // Square sum: one axis per cycle, then the root.
            if (r_sq_run) begin
                r_sum  <= r_sum + SW'(r_m[r_sq_i] * r_m[r_sq_i]);
                r_sq_i <= r_sq_i + 2'd1;
                if (r_sq_i == 2'd2) begin
                    r_sq_run <= 1'b0;
                    r_srun   <= 1'b1;
                    r_rad    <= r_sum + SW'(r_m[2] * r_m[2]);
                    r_root   <= '0;
                    r_rrem   <= '0;
                    r_rcnt   <= RCW'(RW);
                end
            end
            if (r_srun) begin
                logic [SW+1:0] rem2;
                logic [SW+1:0] t;
                rem2 = {r_rrem[SW-1:0], r_rad[SW-1 -: 2]};
                t    = (SW+2)'({r_root, 2'b01});
                r_rad <= r_rad << 2;
                if (rem2 >= t) begin
                    r_rrem <= rem2 - t;
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rrem <= rem2;
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_rcnt <= r_rcnt - 1'b1;
                if (r_rcnt == RCW'(1)) begin
                    r_srun  <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
            if (i_cmd.div_go) begin
                r_num   <= {1'b0, r_step, {FW{1'b0}}};
                r_drem  <= '0;
                r_dcnt  <= QCW'(QW);
                r_drun  <= 1'b1;
                r_ddone <= 1'b0;
            end
            if (r_drun) begin
                logic [RW:0] nr;
                nr = {r_drem[RW-1:0], r_num[QW-1]};
                r_num <= r_num << 1;
                if (nr >= {1'b0, r_root}) begin
                    r_drem <= nr - {1'b0, r_root};
                    r_frac <= {r_frac[FW-2:0], 1'b1};
                end else begin
                    r_drem <= nr;
                    r_frac <= {r_frac[FW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == QCW'(1)) begin
                    r_drun  <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
            if (i_cmd.mul_go) begin
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                r_mcnt  <= MCW'(FW);
                r_mrun  <= 1'b1;
                r_mdone <= 1'b0;
            end
            // The fraction is consumed from its top bit, shifting up each cycle.
            if (r_mrun) begin
                for (int i = 0; i < 3; i++)
                    r_acc[i] <= (r_acc[i] << 1) +
                        (r_frac[FW-1] ? (DW+FW)'(r_m[i]) : '0);
                r_frac <= r_frac << 1;
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == MCW'(1)) begin
                    r_mrun  <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            if (i_cmd.apply) begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [CW-1:0] nv;
                    logic [DW-1:0] q;
                    q  = r_acc[i][DW+FW-1:FW];
                    nv = w_snap ? w_tgt[i]
                       : (r_d[i][DW-1] ? CW'(w_cur[i] - CW'(q)) : CW'(w_cur[i] + CW'(q)));
                    if (i_cmd.chan_rot) r_rot[i] <= nv;
                    else r_pos[i] <= nv;
                end
                if (w_snap) begin
                    if (i_cmd.chan_rot) r_ra <= 1'b0;
                    else r_pa <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.is_tick    = (r_cmd == mtts_pkg::CMD_TICK);
        o_sts.pos_active = r_pa;
        o_sts.rot_active = r_ra;
        o_sts.sqrt_done  = r_sdone;
        o_sts.div_done   = r_ddone;
        o_sts.mul_done   = r_mdone;
        o_sts.snap       = w_snap;
    end

    assign o_result = {r_ra, r_pa,
                       32'(r_rot[2]), 32'(r_rot[1]), 32'(r_rot[0]),
                       32'(r_pos[2]), 32'(r_pos[1]), 32'(r_pos[0])};

    a_snap_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> (r_root != '0)) else $error("divide by zero root");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_srun && r_drun) && !(r_drun && r_mrun)) else $error("units overlap");
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && r_cmd == mtts_pkg::CMD_STOP |=> !r_pa && !r_ra)
        else $error("stop ignored");

endmodule

// File: src/move_toward_target_step_unit.sv
// Linear mover: steps a position and three rotation angles toward targets.
// Input channel s_axis: one item per command. tuser carries the command,
// tdata the three Q20.12 coordinates and the Q4.12 elapsed time.
// Output channel m_axis: exactly one item per input item, showing the
// position, rotation and both moving flags after the command.
// Configuration: i_cfg_we writes move_speed (unsigned Q12.12); the user is to
// write it only while idle, as the block does not enforce this.
// A non-tick command goes from the load state straight to offering its result.
// A tick runs, for each active channel, a square sum of the three axes,
// a bitwise square root, a restoring divide of the step by the root and a
// shift-add scaling of each axis; a channel that snaps skips the divide and
// the scaling, and an idle channel is passed over. The position channel
// is advanced before the rotation channel.
// One item is processed at a time; s_axis_tready is low from accept until
// the result has been taken. The result is held in m_axis_tdata while
// m_axis_tready is low. Reset clears the positions, rotations, targets,
// both flags and the speed.
module move_toward_target_step_unit #(
    parameter int COORD_WIDTH = mtts_pkg::COORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [23:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // coord_x, coord_y, coord_z, elapsed
    input  logic [2:0]    s_axis_tuser,  // command
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [199:0]  m_axis_tdata   // pos_x..z, rot_x..z, position_moving,
                                         // rotation_moving, six zero bits
);

    mtts_pkg::t_dp_cmd w_cmd;
    mtts_pkg::t_dp_sts w_sts;
    logic w_busy, w_done, w_in_fire, w_out_fire;
    logic [193:0] w_res;

    assign s_axis_tready = !w_busy;
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = w_done;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {6'd0, w_res};

    mtts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_out_fire(w_out_fire), .i_sts(w_sts), .o_cmd(w_cmd),
        .o_busy(w_busy), .o_done(w_done)
    );

    mtts_dp #(.CoordWidth(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_command(s_axis_tuser), .i_cx(s_axis_tdata[31:0]), .i_cy(s_axis_tdata[63:32]),
        .i_cz(s_axis_tdata[95:64]), .i_elapsed(s_axis_tdata[111:96]),
        .i_in_fire(w_in_fire), .i_cmd(w_cmd), .o_sts(w_sts), .o_result(w_res)
    );

endmodule

// File: bench/testbench.sv
module testbench;

    // Tracks the mover's state and holds the results that are still owed by the block.
    class mover_tracker;
        logic [23:0]  speed;
        longint       cur[2][3];  // channel 0 position, channel 1 rotation
        longint       tgt[2][3];
        bit           active[2];
        logic [199:0] owed_results[$];
        int           errors;

        function new();
            speed = '0;
            errors = 0;
            foreach (cur[c, a]) begin
                cur[c][a] = 0;
                tgt[c][a] = 0;
            end
            active[0] = 0;
            active[1] = 0;
        endfunction

        function void advance(int ch, longint unsigned step);
            logic [127:0]    sq_sum;
            logic [127:0]    prod;
            longint          d[3];
            longint unsigned mag;
            longint unsigned root;
            longint unsigned cand;
            longint unsigned frac;
            sq_sum = '0;
            for (int a = 0; a < 3; a++) begin
                d[a] = tgt[ch][a] - cur[ch][a];
                mag = (d[a] < 0) ? longint'(-d[a]) : d[a];
                sq_sum += {64'b0, mag} * {64'b0, mag};
            end
            root = 0;
            for (int b = 50; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                prod = {64'b0, cand} * {64'b0, cand};
                if (prod <= sq_sum) root = cand;
            end
            if (step >= root) begin
                for (int a = 0; a < 3; a++) cur[ch][a] = tgt[ch][a];
                active[ch] = 0;
                return;
            end
            frac = (step << 32) / root;
            for (int a = 0; a < 3; a++) begin
                mag = (d[a] < 0) ? longint'(-d[a]) : d[a];
                prod = ({64'b0, mag} * {64'b0, frac}) >> 32;
                if (d[a] < 0) cur[ch][a] -= longint'(prod[63:0]);
                else cur[ch][a] += longint'(prod[63:0]);
            end
        endfunction

        // Notes an accepted item and queues the state that it should leave behind.
        function void note_item(logic [2:0] cmd, logic [111:0] data);
            longint          coord[3];
            longint unsigned step;
            logic [199:0]    res;
            for (int a = 0; a < 3; a++) coord[a] = longint'($signed(data[32*a +: 32]));
            case (cmd)
                mtts_pkg::CMD_TICK: begin
                    step = (longint'(data[111:96]) * longint'(speed)) >> 12;
                    if (step > 64'h7fff_ffff) step = 64'h7fff_ffff;
                    for (int ch = 0; ch < 2; ch++)
                        if (active[ch]) advance(ch, step);
                end
                mtts_pkg::CMD_SET_POS: for (int a = 0; a < 3; a++) cur[0][a] = coord[a];
                mtts_pkg::CMD_SET_ROT: for (int a = 0; a < 3; a++) cur[1][a] = coord[a];
                mtts_pkg::CMD_MOV_POS: begin
                    for (int a = 0; a < 3; a++) tgt[0][a] = coord[a];
                    active[0] = 1;
                end
                mtts_pkg::CMD_MOV_ROT: begin
                    for (int a = 0; a < 3; a++) tgt[1][a] = coord[a];
                    active[1] = 1;
                end
                mtts_pkg::CMD_STOP: begin
                    active[0] = 0;
                    active[1] = 0;
                end
                default: ;
            endcase
            res = '0;
            for (int ch = 0; ch < 2; ch++)
                for (int a = 0; a < 3; a++) res[96*ch + 32*a +: 32] = cur[ch][a][31:0];
            res[192] = active[0];
            res[193] = active[1];
            owed_results.push_back(res);
        endfunction

        // Compares a delivered result with the oldest one owed, field by field.
        function void check_result(logic [199:0] got);
            logic [199:0] want;
            if (owed_results.size() == 0) begin
                $display("%0t: result %h arrived with none owed", $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            for (int f = 0; f < 6; f++)
                if (got[32*f +: 32] !== want[32*f +: 32]) begin
                    $display("%0t: word %0d expected %h actual %h", $time, f,
                             want[32*f +: 32], got[32*f +: 32]);
                    errors++;
                end
            for (int f = 192; f < 194; f++)
                if (got[f] !== want[f]) begin
                    $display("%0t: moving flag bit %0d expected %b actual %b", $time, f,
                             want[f], got[f]);
                    errors++;
                end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;   // coord_x, coord_y, coord_z, elapsed
    logic [2:0]   s_axis_tuser = '0;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [199:0] m_axis_tdata;        // pos_x..z, rot_x..z, position_moving, rotation_moving

    mover_tracker tracker = new();
    int  items_accepted = 0;
    int  burst_left = 0;
    bit  long_hold = 0;
    bit  stim_done = 0;

    always #5 i_clk = ~i_clk;

    move_toward_target_step_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Offers one item and waits for the block to take it. Between bursts the valid
    // line may drop for a random gap; inside a burst it stays high across items.
    task automatic send_item(logic [2:0] cmd, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [15:0] el);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {el, z, y, x};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        tracker.note_item(s_axis_tuser, s_axis_tdata);
        items_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // Waits until every owed result has come back, then writes the speed register.
    task automatic write_speed(logic [23:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.speed = value;
    endtask

    // Coordinates: mostly within a modest range so that motions take several ticks,
    // now and then any 32-bit value.
    function automatic logic [31:0] pick_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    task automatic random_items(int count);
        int          roll;
        logic [15:0] el;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            el = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
            if (roll < 45) send_item(mtts_pkg::CMD_TICK, $urandom, $urandom, $urandom, el);
            else if (roll < 55) send_item(mtts_pkg::CMD_MOV_POS, pick_coord(), pick_coord(),
                                          pick_coord(), el);
            else if (roll < 65) send_item(mtts_pkg::CMD_MOV_ROT, pick_coord(), pick_coord(),
                                          pick_coord(), el);
            else if (roll < 75) send_item(mtts_pkg::CMD_SET_POS, pick_coord(), pick_coord(),
                                          pick_coord(), el);
            else if (roll < 85) send_item(mtts_pkg::CMD_SET_ROT, pick_coord(), pick_coord(),
                                          pick_coord(), el);
            else if (roll < 92) send_item(mtts_pkg::CMD_STOP, $urandom, $urandom, $urandom, el);
            else send_item(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, el);
        end
    endtask

    // Receiver: a stall pattern that moves between full readiness, readiness
    // three times in four and half the time, plus the long hold-off below.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
        if (long_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (($time / 640) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // A long hold-off midway: the receiver stops while the sender keeps offering,
    // so the block sits on its result and lowers its input ready.
    initial begin
        wait (items_accepted >= 500);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (600) @(posedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        logic [23:0] speeds[5];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at one unit per second.
        write_speed(24'h00_1000);
        send_item(mtts_pkg::CMD_SET_POS, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h0);
        send_item(mtts_pkg::CMD_MOV_POS, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'h0);      // zero step: no move
        send_item(mtts_pkg::CMD_SET_POS, 32'h0, 32'h0, 32'h0, 16'h0);
        send_item(mtts_pkg::CMD_MOV_POS, 32'h0000_8000, 32'hffff_c000, 32'h0000_3000, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'h0800);
        // Setting the position mid-motion keeps the motion going from there.
        send_item(mtts_pkg::CMD_SET_POS, 32'h0000_1000, 32'h0, 32'h0, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'h1000);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);   // snaps to target
        send_item(mtts_pkg::CMD_SET_ROT, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 16'h0);
        send_item(mtts_pkg::CMD_MOV_ROT, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'h0);      // zero distance: snaps
        send_item(mtts_pkg::CMD_MOV_ROT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0);
        send_item(mtts_pkg::CMD_MOV_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'h4000);
        send_item(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        send_item(3'd7, 32'h0, 32'h0, 32'h0, 16'h0);
        send_item(mtts_pkg::CMD_STOP, 32'h0, 32'h0, 32'h0, 16'h0);
        send_item(mtts_pkg::CMD_TICK, 32'h0, 32'h0, 32'h0, 16'hffff);

        // Random phases across the speed range, extremes included.
        speeds[0] = 24'hff_ffff;
        speeds[1] = 24'h00_0000;
        speeds[2] = 24'h00_0001;
        speeds[3] = 24'($urandom_range(24'h00_0800, 24'h08_0000));
        speeds[4] = 24'($urandom);
        foreach (speeds[p]) begin
            write_speed(speeds[p]);
            random_items(p == 1 ? 90 : 260);
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
